### src/sm83_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sm83_pkg;

    localparam int DataW = 8;
    localparam int WideW = 16;
    localparam int OpW   = 5;
    localparam int FlagW = 4;
    localparam int BitW  = 3;

    localparam logic [OpW-1:0] OP_ADD    = 5'd0;
    localparam logic [OpW-1:0] OP_ADC    = 5'd1;
    localparam logic [OpW-1:0] OP_SUB    = 5'd2;
    localparam logic [OpW-1:0] OP_SBC    = 5'd3;
    localparam logic [OpW-1:0] OP_AND    = 5'd4;
    localparam logic [OpW-1:0] OP_XOR    = 5'd5;
    localparam logic [OpW-1:0] OP_OR     = 5'd6;
    localparam logic [OpW-1:0] OP_CP     = 5'd7;
    localparam logic [OpW-1:0] OP_INC8   = 5'd8;
    localparam logic [OpW-1:0] OP_DEC8   = 5'd9;
    localparam logic [OpW-1:0] OP_ADD16  = 5'd10;
    localparam logic [OpW-1:0] OP_SP_REL = 5'd11;
    localparam logic [OpW-1:0] OP_RLC    = 5'd12;
    localparam logic [OpW-1:0] OP_RRC    = 5'd13;
    localparam logic [OpW-1:0] OP_RL     = 5'd14;
    localparam logic [OpW-1:0] OP_RR     = 5'd15;
    localparam logic [OpW-1:0] OP_SLA    = 5'd16;
    localparam logic [OpW-1:0] OP_SRA    = 5'd17;
    localparam logic [OpW-1:0] OP_SWAP   = 5'd18;
    localparam logic [OpW-1:0] OP_SRL    = 5'd19;
    localparam logic [OpW-1:0] OP_BIT    = 5'd20;
    localparam logic [OpW-1:0] OP_RES    = 5'd21;
    localparam logic [OpW-1:0] OP_SET    = 5'd22;

    // flag bit positions
    localparam int FlagZ = 3;
    localparam int FlagN = 2;
    localparam int FlagH = 1;
    localparam int FlagC = 0;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             carry;
        logic             bit_zero;
    } rb_res_t;

endpackage

`default_nettype wire

### src/sm83_rot_bit.sv
`timescale 1ns / 1ps
`default_nettype none

module sm83_rot_bit
    import sm83_pkg::*;
(
    input  wire logic [OpW-1:0]   op,
    input  wire logic [DataW-1:0] a,
    input  wire logic             cin,
    input  wire logic [BitW-1:0]  bit_index,
    output rb_res_t               res
);

    logic [DataW-1:0] mask;

    assign mask = DataW'(1) << bit_index;

    always_comb begin
        res.value    = a;
        res.carry    = 1'b0;
        res.bit_zero = ~a[bit_index];
        unique case (op)
            OP_RLC: begin
                res.value = {a[DataW-2:0], a[DataW-1]};
                res.carry = a[DataW-1];
            end
            OP_RRC: begin
                res.value = {a[0], a[DataW-1:1]};
                res.carry = a[0];
            end
            OP_RL: begin
                res.value = {a[DataW-2:0], cin};
                res.carry = a[DataW-1];
            end
            OP_RR: begin
                res.value = {cin, a[DataW-1:1]};
                res.carry = a[0];
            end
            OP_SLA: begin
                res.value = {a[DataW-2:0], 1'b0};
                res.carry = a[DataW-1];
            end
            OP_SRA: begin
                res.value = {a[DataW-1], a[DataW-1:1]};
                res.carry = a[0];
            end
            OP_SWAP: begin
                res.value = {a[3:0], a[7:4]};
            end
            OP_SRL: begin
                res.value = {1'b0, a[DataW-1:1]};
                res.carry = a[0];
            end
            OP_RES: begin
                res.value = a & ~mask;
            end
            OP_SET: begin
                res.value = a | mask;
            end
            default: begin
                res.value = a;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sm83_alu_and_bit_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// three register stages; an accepted item moves through stage 1, stage 2 and stage 3,
// and its result leaves from the stage 3 registers
// throughput: one item per cycle; each stage moves when the one after it has room
// stage 1 decodes and shifts, stage 2 runs the adders, stage 3 selects result and flags
// reset: synchronous active-low aresetn clears all stage valid bits

module sm83_alu_and_bit_unit
    import sm83_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] first_operand, [31:16] second_operand, [35:32] flags_in,
    // [38:36] bit_index, [39] zero
    input  wire logic [39:0] s_tdata,
    // [4:0] op
    input  wire logic [4:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] result, [19:16] flags_out, [20] write_result, [23:21] zero
    output logic [23:0]      m_tdata
);

    // input field split
    logic [OpW-1:0]   in_op;
    logic [WideW-1:0] in_x;
    logic [WideW-1:0] in_y;
    logic [FlagW-1:0] in_fl;
    logic [BitW-1:0]  in_bi;
    logic             in_c;
    rb_res_t          in_rb;

    assign in_op = s_tuser;
    assign in_x  = s_tdata[15:0];
    assign in_y  = s_tdata[31:16];
    assign in_fl = s_tdata[35:32];
    assign in_bi = s_tdata[38:36];
    assign in_c  = ((in_op == OP_ADC) || (in_op == OP_SBC)) ? in_fl[FlagC] : 1'b0;

    sm83_rot_bit u_rot_bit (
        .op        (in_op),
        .a         (in_x[DataW-1:0]),
        .cin       (in_fl[FlagC]),
        .bit_index (in_bi),
        .res       (in_rb)
    );

    // handshake chain
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // stage 1 payload
    logic [OpW-1:0]   op1_reg;
    logic [WideW-1:0] x1_reg;
    logic [WideW-1:0] wy1_reg;
    logic [DataW-1:0] b1_reg;
    logic [FlagW-1:0] fl1_reg;
    logic             c1_reg;
    rb_res_t          rb1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            op1_reg <= in_op;
            x1_reg  <= in_x;
            b1_reg  <= in_y[DataW-1:0];
            // sp_rel adds the sign-extended low byte
            wy1_reg <= (in_op == OP_SP_REL) ? {{DataW{in_y[DataW-1]}}, in_y[DataW-1:0]}
                                            : in_y;
            fl1_reg <= in_fl;
            c1_reg  <= in_c;
            rb1_reg <= in_rb;
        end
    end

    // stage 2 payload: adders
    logic [OpW-1:0]   op2_reg;
    logic [DataW-1:0] a2_reg;
    logic [FlagW-1:0] fl2_reg;
    rb_res_t          rb2_reg;
    logic [DataW:0]   sum_reg;
    logic [4:0]       hsum_reg;
    logic [DataW:0]   diff_reg;
    logic [4:0]       hdiff_reg;
    logic [WideW:0]   wsum_reg;
    logic [12:0]      wh_reg;
    logic [DataW-1:0] logic_reg;
    logic [DataW-1:0] inc_reg;
    logic [DataW-1:0] dec_reg;

    logic [DataW-1:0] a1;
    assign a1 = x1_reg[DataW-1:0];

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            op2_reg   <= op1_reg;
            a2_reg    <= a1;
            fl2_reg   <= fl1_reg;
            rb2_reg   <= rb1_reg;
            sum_reg   <= {1'b0, a1} + {1'b0, b1_reg} + {{DataW{1'b0}}, c1_reg};
            hsum_reg  <= {1'b0, a1[3:0]} + {1'b0, b1_reg[3:0]} + {4'd0, c1_reg};
            diff_reg  <= {1'b0, a1} - {1'b0, b1_reg} - {{DataW{1'b0}}, c1_reg};
            hdiff_reg <= {1'b0, a1[3:0]} - {1'b0, b1_reg[3:0]} - {4'd0, c1_reg};
            wsum_reg  <= {1'b0, x1_reg} + {1'b0, wy1_reg};
            wh_reg    <= {1'b0, x1_reg[11:0]} + {1'b0, wy1_reg[11:0]};
            inc_reg   <= a1 + DataW'(1);
            dec_reg   <= a1 - DataW'(1);
            unique case (op1_reg)
                OP_AND:  logic_reg <= a1 & b1_reg;
                OP_XOR:  logic_reg <= a1 ^ b1_reg;
                default: logic_reg <= a1 | b1_reg;
            endcase
        end
    end

    // stage 3: result and flag select
    logic [WideW-1:0] r_next;
    logic [FlagW-1:0] f_next;
    logic             w_next;
    logic [DataW-1:0] r8;
    logic             r8_zero;

    always_comb begin
        r8 = '0;
        unique case (op2_reg)
            OP_ADD, OP_ADC:          r8 = sum_reg[DataW-1:0];
            OP_SUB, OP_SBC, OP_CP:   r8 = diff_reg[DataW-1:0];
            OP_AND, OP_XOR, OP_OR:   r8 = logic_reg;
            OP_INC8:                 r8 = inc_reg;
            OP_DEC8:                 r8 = dec_reg;
            default:                 r8 = rb2_reg.value;
        endcase
    end

    assign r8_zero = (r8 == '0);

    always_comb begin
        r_next = {{DataW{1'b0}}, r8};
        f_next = fl2_reg;
        w_next = 1'b1;
        unique case (op2_reg)
            OP_ADD, OP_ADC: begin
                f_next = {r8_zero, 1'b0, hsum_reg[4], sum_reg[DataW]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                f_next = {r8_zero, 1'b1, hdiff_reg[4], diff_reg[DataW]};
                w_next = (op2_reg != OP_CP);
            end
            OP_AND: begin
                f_next = {r8_zero, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR, OP_OR: begin
                f_next = {r8_zero, 3'b000};
            end
            OP_INC8: begin
                f_next = {r8_zero, 1'b0, (r8[3:0] == 4'h0), fl2_reg[FlagC]};
            end
            OP_DEC8: begin
                f_next = {r8_zero, 1'b1, (r8[3:0] == 4'hF), fl2_reg[FlagC]};
            end
            OP_ADD16: begin
                r_next = wsum_reg[WideW-1:0];
                f_next = {fl2_reg[FlagZ], 1'b0, wh_reg[12], wsum_reg[WideW]};
            end
            OP_SP_REL: begin
                // carries come from the unsigned low-byte sum
                r_next = wsum_reg[WideW-1:0];
                f_next = {2'b00, hsum_reg[4], sum_reg[DataW]};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                f_next = {r8_zero, 2'b00, rb2_reg.carry};
            end
            OP_BIT: begin
                r_next = {{DataW{1'b0}}, a2_reg};
                f_next = {rb2_reg.bit_zero, 1'b0, 1'b1, fl2_reg[FlagC]};
                w_next = 1'b0;
            end
            OP_RES, OP_SET: begin
                f_next = fl2_reg;
            end
            default: begin
                r_next = '0;
                w_next = 1'b0;
            end
        endcase
    end

    logic [WideW-1:0] res_reg;
    logic [FlagW-1:0] flags_reg;
    logic             wr_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            res_reg   <= r_next;
            flags_reg <= f_next;
            wr_reg    <= w_next;
        end
    end

    assign m_tdata = {3'b000, wr_reg, flags_reg, res_reg};

    // checks on the stage chain
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !v1_reg && !v2_reg)
        else $error("pipeline not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !rdy3 |=> v2_reg && $stable(wsum_reg) && $stable(op2_reg))
        else $error("stage 2 changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && !m_tready |-> !s_tready)
        else $error("input accepted with every stage full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        rdy3 && v2_reg && (op2_reg == OP_CP || op2_reg == OP_BIT) |=> !m_tdata[20])
        else $error("compare or bit test wrote its result");

endmodule

`default_nettype wire

### tb/sm83_alu_and_bit_unit_test.sv
`timescale 1ns / 1ps

module sm83_alu_and_bit_unit_test;
    import sm83_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 20;
    localparam int ReportMax   = 10;

    // codes with no operation behind them
    localparam logic [OpW-1:0] OpFirstUnused = 5'd23;
    localparam logic [OpW-1:0] OpLastUnused  = 5'd31;

    typedef struct {
        logic [OpW-1:0]   op;
        logic [WideW-1:0] value;
        logic [FlagW-1:0] flags;
        logic             write;
    } alu_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    alu_out_t pending_results[$];
    int       error_count = 0;
    int       items_accepted = 0;
    int       results_checked = 0;
    int       op_hits[32];
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b1;
    int       stall_left = 0;
    int       stall_mode = 0;

    sm83_alu_and_bit_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [FlagW-1:0] make_flags(logic z, logic n, logic h, logic c);
        logic [FlagW-1:0] f;
        f = '0;
        f[FlagZ] = z;
        f[FlagN] = n;
        f[FlagH] = h;
        f[FlagC] = c;
        return f;
    endfunction

    function automatic alu_out_t execute_op(logic [OpW-1:0] op, logic [WideW-1:0] x,
                                            logic [WideW-1:0] y, logic [FlagW-1:0] fl,
                                            logic [BitW-1:0] bi);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r;
        logic        cin;
        logic        c;
        logic        co;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        alu_out_t    o;
        a = x[7:0];
        b = y[7:0];
        cin = fl[FlagC];
        o.op = op;
        o.value = '0;
        o.flags = fl;
        o.write = 1'b1;
        case (op)
            OP_ADD, OP_ADC: begin
                c = (op == OP_ADC) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, b} + c;
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + c;
                o.value = {8'h00, s9[7:0]};
                o.flags = make_flags(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
            end
            OP_SUB, OP_SBC, OP_CP: begin
                // bit 8 / bit 4 of the wide difference is the borrow
                c = (op == OP_SBC) ? cin : 1'b0;
                s9 = {1'b0, a} - {1'b0, b} - c;
                s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - c;
                o.value = {8'h00, s9[7:0]};
                o.flags = make_flags(s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]);
                o.write = (op != OP_CP);
            end
            OP_AND: begin
                r = a & b;
                o.value = {8'h00, r};
                o.flags = make_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR, OP_OR: begin
                r = (op == OP_XOR) ? (a ^ b) : (a | b);
                o.value = {8'h00, r};
                o.flags = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_INC8: begin
                r = a + 8'd1;
                o.value = {8'h00, r};
                o.flags = make_flags(r == 8'h00, 1'b0, r[3:0] == 4'h0, cin);
            end
            OP_DEC8: begin
                r = a - 8'd1;
                o.value = {8'h00, r};
                o.flags = make_flags(r == 8'h00, 1'b1, r[3:0] == 4'hF, cin);
            end
            OP_ADD16: begin
                s17 = {1'b0, x} + {1'b0, y};
                s13 = {1'b0, x[11:0]} + {1'b0, y[11:0]};
                o.value = s17[15:0];
                o.flags = make_flags(fl[FlagZ], 1'b0, s13[12], s17[16]);
            end
            OP_SP_REL: begin
                // carries come from the unsigned low-byte sum
                s9 = {1'b0, x[7:0]} + {1'b0, b};
                s5 = {1'b0, x[3:0]} + {1'b0, b[3:0]};
                o.value = x + {{8{b[7]}}, b};
                o.flags = make_flags(1'b0, 1'b0, s5[4], s9[8]);
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                co = 1'b0;
                r = a;
                case (op)
                    OP_RLC:  begin co = a[7]; r = {a[6:0], a[7]}; end
                    OP_RRC:  begin co = a[0]; r = {a[0], a[7:1]}; end
                    OP_RL:   begin co = a[7]; r = {a[6:0], cin}; end
                    OP_RR:   begin co = a[0]; r = {cin, a[7:1]}; end
                    OP_SLA:  begin co = a[7]; r = {a[6:0], 1'b0}; end
                    OP_SRA:  begin co = a[0]; r = {a[7], a[7:1]}; end
                    OP_SWAP: begin r = {a[3:0], a[7:4]}; end
                    default: begin co = a[0]; r = {1'b0, a[7:1]}; end
                endcase
                o.value = {8'h00, r};
                o.flags = make_flags(r == 8'h00, 1'b0, 1'b0, co);
            end
            OP_BIT: begin
                o.value = {8'h00, a};
                o.flags = make_flags(~a[bi], 1'b0, 1'b1, cin);
                o.write = 1'b0;
            end
            OP_RES: begin
                r = a;
                r[bi] = 1'b0;
                o.value = {8'h00, r};
            end
            OP_SET: begin
                r = a;
                r[bi] = 1'b1;
                o.value = {8'h00, r};
            end
            default: begin
                o.write = 1'b0;
            end
        endcase
        return o;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= ReportMax)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // predict on the input side first so a same-edge result still finds its entry
    always @(posedge aclk) begin
        alu_out_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(execute_op(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                                     s_tdata[35:32], s_tdata[38:36]));
                op_hits[s_tuser]++;
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    log_error($sformatf("unexpected result item %h", m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (m_tdata[15:0] !== want.value || m_tdata[19:16] !== want.flags ||
                        m_tdata[20] !== want.write)
                        log_error($sformatf({"op %0d: expected result %h flags %b write %b,",
                                             " got result %h flags %b write %b"},
                                            want.op, want.value, want.flags, want.write,
                                            m_tdata[15:0], m_tdata[19:16], m_tdata[20]));
                end
            end
        end
    end

    // receiver picks a new stall mode whenever its stall counter runs out
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    task automatic send_op(input logic [OpW-1:0] op, input logic [WideW-1:0] x,
                           input logic [WideW-1:0] y, input logic [FlagW-1:0] fl,
                           input logic [BitW-1:0] bi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = 0;
            if (gaps_on && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, bi, fl, y, x};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // mostly uniform, with a share of carry and sign corners
    function automatic logic [WideW-1:0] pick_operand();
        logic [WideW-1:0] corners[8];
        corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'h0FFF, 16'h0F0F, 16'h8080,
                    16'hF000, 16'h7F01};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return WideW'($urandom);
    endfunction

    function automatic logic [OpW-1:0] pick_op();
        if ($urandom_range(0, 15) == 0)
            return OpW'($urandom_range(OpFirstUnused, OpLastUnused));
        return OpW'($urandom_range(OP_ADD, OP_SET));
    endfunction

    task automatic test_each_op_directed();
        send_op(OP_ADD,    16'hABFF, 16'h1201, 4'b0000, 3'd0); // wraps to zero, both carries
        send_op(OP_ADC,    16'h000F, 16'h0000, 4'b0001, 3'd1); // carry in makes half carry
        send_op(OP_SUB,    16'h0000, 16'h0001, 4'b0000, 3'd2);
        send_op(OP_SBC,    16'h0010, 16'h0000, 4'b1111, 3'd3);
        send_op(OP_AND,    16'hFFF0, 16'hFF0F, 4'b1111, 3'd4);
        send_op(OP_XOR,    16'h125A, 16'h345A, 4'b0000, 3'd5);
        send_op(OP_OR,     16'h0080, 16'hFF01, 4'b1010, 3'd6);
        send_op(OP_CP,     16'h0042, 16'h8042, 4'b0000, 3'd7); // equal, no write back
        send_op(OP_INC8,   16'h55FF, 16'hFFFF, 4'b0001, 3'd0);
        send_op(OP_DEC8,   16'hAA00, 16'h0000, 4'b0000, 3'd1);
        send_op(OP_ADD16,  16'h0FFF, 16'h0001, 4'b1000, 3'd2); // z passes through
        send_op(OP_ADD16,  16'hFFFF, 16'h0001, 4'b0000, 3'd3);
        send_op(OP_SP_REL, 16'hFFF8, 16'hFF08, 4'b1111, 3'd4);
        send_op(OP_SP_REL, 16'h0000, 16'h0080, 4'b1111, 3'd5); // most negative offset
        send_op(OP_RLC,    16'hFF80, 16'h0000, 4'b0000, 3'd6);
        send_op(OP_RRC,    16'h0001, 16'hFFFF, 4'b1111, 3'd7);
        send_op(OP_RL,     16'h0080, 16'h0000, 4'b0000, 3'd0); // shifts out to zero
        send_op(OP_RR,     16'h0001, 16'h0000, 4'b0001, 3'd1);
        send_op(OP_SLA,    16'h0080, 16'h0000, 4'b0110, 3'd2);
        send_op(OP_SRA,    16'h0081, 16'h0000, 4'b0000, 3'd3);
        send_op(OP_SWAP,   16'h00F0, 16'h0000, 4'b1111, 3'd4);
        send_op(OP_SRL,    16'h0001, 16'h0000, 4'b0000, 3'd5);
        send_op(OP_BIT,    16'hFF7F, 16'h0000, 4'b0101, 3'd7); // operand byte comes back
        send_op(OP_RES,    16'h00FF, 16'h0000, 4'b1010, 3'd0);
        send_op(OP_SET,    16'hFF00, 16'h0000, 4'b0101, 3'd7);
        send_op(OpLastUnused, 16'hFFFF, 16'hFFFF, 4'b1001, 3'd7);
    endtask

    task automatic test_bit_index_sweep();
        logic [OpW-1:0] ops[3];
        ops = '{OP_BIT, OP_RES, OP_SET};
        foreach (ops[k])
            for (int i = 0; i < 8; i++)
                send_op(ops[k], pick_operand(), pick_operand(), FlagW'($urandom),
                        i[BitW-1:0]);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_op(pick_op(), pick_operand(), pick_operand(), FlagW'($urandom),
                    BitW'($urandom));
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        burst_left = 0;
        repeat (count)
            send_op(pick_op(), pick_operand(), pick_operand(), FlagW'($urandom),
                    BitW'($urandom));
        gaps_on = 1'b1;
    endtask

    initial begin
        int distinct_ops;
        distinct_ops = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_each_op_directed();
        test_bit_index_sweep();
        test_random_mix(800);
        test_back_to_back(250);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        foreach (op_hits[i])
            if (op_hits[i] != 0)
                distinct_ops++;
        $display("sent %0d items over %0d distinct op codes, %0d results checked",
                 items_accepted, distinct_ops, results_checked);
        $display("sender gaps and receiver stalls mixed with back-to-back stretches, %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
src/sm83_pkg.sv
src/sm83_rot_bit.sv
src/sm83_alu_and_bit_unit.sv
tb/sm83_alu_and_bit_unit_test.sv
